/* rtl/core/xo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package xo_pkg;
	localparam logic [1:0] OP_RESEED  = 2'd0;
	localparam logic [1:0] OP_RAW     = 2'd1;
	localparam logic [1:0] OP_BOUNDED = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] seed_value;
		logic [63:0] draw_bound;
	} xo_req_t;

	typedef struct packed {
		logic [63:0] random_value;
	} xo_rsp_t;

	// shared multiplier request and answer
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} xo_mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} xo_mul_rsp_t;

	// shared divider request and answer
	typedef struct packed {
		logic        start;
		logic [63:0] n;
		logic [63:0] d;
	} xo_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] r;
	} xo_div_rsp_t;
endpackage
`default_nettype wire

/* rtl/core/xo_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface xo_req_if;
	logic            valid;
	logic            ready;
	xo_pkg::xo_req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface xo_rsp_if;
	logic            valid;
	logic            ready;
	xo_pkg::xo_rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/xoshiro256ss_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// xoshiro256** generator with splitmix64 reseeding.
// Channels: req (opcode, seed_value, draw_bound) in, rsp (random_value) out,
// both valid/ready; a transfer happens when valid and ready are high together.
// One command at a time: req.ready is high only while the sequencer is idle.
// Steps per command, from the command transfer to result valid:
//   raw draw      two passes through the multiplier
//   reseed        eight multiplies, two per splitmix step
//   bounded draw  divider for the limit, a raw draw repeated while it is
//                 rejected, then the divider again for the final remainder
//   zero bound / unused opcode: straight to the result register
// Commands do not overlap: the next command is accepted only after the
// result transfers.
// The multiplier handles 16 bits of one operand per cycle and the divider one
// bit per cycle.
// Reset: the state words load the splitmix64 expansion of seed zero.
// Result is held in an output register; the sequencer waits while the
// receiver stalls and takes the next command after the result transfers.
module xoshiro256ss_generator (
	input wire logic  clk,
	input wire logic  arst_n,
	xo_req_if.sink    req,
	xo_rsp_if.source  rsp
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SM1   = 4'd1;
	localparam logic [3:0] ST_SM2   = 4'd2;
	localparam logic [3:0] ST_SMFIN = 4'd3;
	localparam logic [3:0] ST_RAW1  = 4'd4;
	localparam logic [3:0] ST_RAW2  = 4'd5;
	localparam logic [3:0] ST_LIMIT = 4'd6;
	localparam logic [3:0] ST_MOD   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	// splitmix64 expansion of seed zero
	localparam logic [63:0] INIT_W0 = 64'he220a8397b1dcdaf;
	localparam logic [63:0] INIT_W1 = 64'h6e789e6aa1b965f4;
	localparam logic [63:0] INIT_W2 = 64'h06c45d188009454f;
	localparam logic [63:0] INIT_W3 = 64'hf88bb8a8724c81ec;

	logic [3:0]  state_q;
	logic [63:0] w_q [4];
	logic [63:0] sm_q;
	logic [1:0]  idx_q;
	logic [1:0]  op_q;
	logic [63:0] bound_q;
	logic [63:0] limit_q;
	logic [63:0] draw_q;
	logic [63:0] out_q;
	logic        out_valid_q;
	logic        mstart;
	logic [63:0] ma;
	logic [63:0] mb;
	logic        dstart;
	logic [63:0] dn;
	logic [63:0] dd;
	logic [63:0] z30;
	logic [63:0] z27;
	logic [63:0] rot7;
	logic [63:0] t17;
	logic [63:0] n2;
	logic [63:0] n3;
	xo_pkg::xo_mul_req_t mreq;
	xo_pkg::xo_mul_rsp_t mrsp;
	xo_pkg::xo_div_req_t dreq;
	xo_pkg::xo_div_rsp_t drsp;

	assign mreq = '{start: mstart, a: ma, b: mb};
	assign dreq = '{start: dstart, n: dn, d: dd};

	xo_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	xo_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign req.ready         = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid         = out_valid_q;
	assign rsp.payload.random_value = out_q;

	// mixing and state-update helpers
	assign z30  = mrsp.p ^ (mrsp.p >> 27);
	assign z27  = mrsp.p ^ (mrsp.p >> 31);
	assign rot7 = {mrsp.p[56:0], mrsp.p[63:57]};
	assign t17  = w_q[1] << 17;
	assign n2   = w_q[2] ^ w_q[0];
	assign n3   = w_q[3] ^ w_q[1];

	// start the shared units for the step being entered
	always_comb begin
		mstart = 1'b0;
		ma     = '0;
		mb     = '0;
		dstart = 1'b0;
		dn     = '0;
		dd     = bound_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid && req.ready) begin
					ma = req.payload.seed_value + xo_pkg::GOLDEN_GAMMA;
					ma = ma ^ (ma >> 30);
					mb = xo_pkg::MIX_MUL_A;
					mstart = (req.payload.opcode == xo_pkg::OP_RESEED);
					if (req.payload.opcode == xo_pkg::OP_RAW) begin
						ma = w_q[1];
						mb = 64'd5;
						mstart = 1'b1;
					end
					if (req.payload.opcode == xo_pkg::OP_BOUNDED &&
					    req.payload.draw_bound != 64'd0) begin
						dn = 64'd0 - req.payload.draw_bound;
						dd = req.payload.draw_bound;
						dstart = 1'b1;
					end
				end
			end
			ST_SM1: begin
				if (mrsp.done) begin
					ma = z30;
					mb = xo_pkg::MIX_MUL_B;
					mstart = 1'b1;
				end
			end
			ST_SM2: begin
				if (mrsp.done && idx_q != 2'd3) begin
					ma = (sm_q + xo_pkg::GOLDEN_GAMMA) ^
					     ((sm_q + xo_pkg::GOLDEN_GAMMA) >> 30);
					mb = xo_pkg::MIX_MUL_A;
					mstart = 1'b1;
				end
			end
			ST_RAW1: begin
				if (mrsp.done) begin
					ma = rot7;
					mb = 64'd9;
					mstart = 1'b1;
				end
			end
			ST_LIMIT: begin
				if (drsp.done) begin
					ma = w_q[1];
					mb = 64'd5;
					mstart = 1'b1;
				end
			end
			ST_RAW2: begin
				if (mrsp.done && op_q == xo_pkg::OP_BOUNDED) begin
					if (mrsp.p < limit_q) begin
						ma = w_q[1] ^ n2;
						mb = 64'd5;
						mstart = 1'b1;
					end else begin
						dn = mrsp.p;
						dstart = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			op_q        <= '0;
			w_q[0]      <= INIT_W0;
			w_q[1]      <= INIT_W1;
			w_q[2]      <= INIT_W2;
			w_q[3]      <= INIT_W3;
		end else begin
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						op_q    <= req.payload.opcode;
						bound_q <= req.payload.draw_bound;
						sm_q    <= req.payload.seed_value + xo_pkg::GOLDEN_GAMMA;
						idx_q   <= '0;
						out_q   <= '0;
						case (req.payload.opcode)
							xo_pkg::OP_RESEED: state_q <= ST_SM1;
							xo_pkg::OP_RAW:    state_q <= ST_RAW1;
							xo_pkg::OP_BOUNDED:
								state_q <= (req.payload.draw_bound == 64'd0) ?
								           ST_OUT : ST_LIMIT;
							default:           state_q <= ST_OUT;
						endcase
					end
				end
				ST_SM1: begin
					if (mrsp.done)
						state_q <= ST_SM2;
				end
				ST_SM2: begin
					if (mrsp.done) begin
						w_q[idx_q] <= z27;
						idx_q      <= idx_q + 2'd1;
						sm_q       <= sm_q + xo_pkg::GOLDEN_GAMMA;
						state_q    <= (idx_q == 2'd3) ? ST_SMFIN : ST_SM1;
					end
				end
				ST_SMFIN: begin
					// all-zero state gets word 0 forced to one
					if ((w_q[0] | w_q[1] | w_q[2] | w_q[3]) == 64'd0)
						w_q[0] <= 64'd1;
					state_q <= ST_OUT;
				end
				ST_LIMIT: begin
					if (drsp.done) begin
						limit_q <= drsp.r;
						state_q <= ST_RAW1;
					end
				end
				ST_RAW1: begin
					if (mrsp.done)
						state_q <= ST_RAW2;
				end
				ST_RAW2: begin
					if (mrsp.done) begin
						// advance the state words
						w_q[2] <= n2 ^ t17;
						w_q[3] <= {n3[18:0], n3[63:19]};
						w_q[1] <= w_q[1] ^ n2;
						w_q[0] <= w_q[0] ^ n3;
						draw_q <= mrsp.p;
						if (op_q != xo_pkg::OP_BOUNDED) begin
							out_q   <= mrsp.p;
							state_q <= ST_OUT;
						end else if (mrsp.p < limit_q) begin
							state_q <= ST_RAW1;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (drsp.done) begin
						out_q   <= drsp.r;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register holds while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_q))
		else $error("result changed under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req.ready)
		else $error("ready while busy");
	a_draw_kept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> draw_q >= limit_q)
		else $error("rejected draw reduced");
endmodule
`default_nettype wire

/* rtl/core/xo_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// 64x64 low-half product, one 16x64 partial product per cycle
module xo_mul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  xo_pkg::xo_mul_req_t  req,
	output xo_pkg::xo_mul_rsp_t  rsp
);
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [79:0] part;

	// one 16-bit slice of b times a
	assign part = a_q * {64'd0, b_q[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd3)
				busy_q <= 1'b0;
		end
	end

	// accumulate and advance operand slices
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part[63:0];
			a_q   <= a_q << 16;
			b_q   <= b_q >> 16;
		end
	end

	assign rsp.done = busy_q && (cnt_q == 3'd3);
	assign rsp.p    = acc_q + part[63:0];
endmodule
`default_nettype wire

/* rtl/core/xo_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// 64-bit restoring remainder, one quotient bit per cycle
module xo_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  xo_pkg::xo_div_req_t  req,
	output xo_pkg::xo_div_rsp_t  rsp
);
	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [64:0] r_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] shifted;
	logic [64:0] diff;

	assign shifted = {r_q[63:0], n_q[63]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd63)
				busy_q <= 1'b0;
		end
	end

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.n;
			d_q <= req.d;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= diff[64] ? shifted : diff;
		end
	end

	assign rsp.done = busy_q && (cnt_q == 7'd63);
	assign rsp.r    = diff[64] ? shifted[63:0] : diff[63:0];
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	localparam int RANDOM_ITEMS = 900;
	localparam longint CYCLE_LIMIT = 2000000;

	// Mirror of the generator state and the queue of expected values.
	class rng_scoreboard;
		logic [63:0] words [4];
		logic [63:0] pending_values [$];
		int mismatches;

		function logic [63:0] rotl(logic [63:0] x, int k);
			return (x << k) | (x >> (64 - k));
		endfunction

		function logic [63:0] mix_next(ref logic [63:0] sm);
			logic [63:0] z;
			sm = sm + xo_pkg::GOLDEN_GAMMA;
			z = sm;
			z = (z ^ (z >> 30)) * xo_pkg::MIX_MUL_A;
			z = (z ^ (z >> 27)) * xo_pkg::MIX_MUL_B;
			return z ^ (z >> 31);
		endfunction

		function void load_seed(logic [63:0] seed);
			logic [63:0] sm;
			sm = seed;
			for (int i = 0; i < 4; i++) words[i] = mix_next(sm);
			if ((words[0] | words[1] | words[2] | words[3]) == 64'd0) words[0] = 64'd1;
		endfunction

		function logic [63:0] next_raw();
			logic [63:0] res;
			logic [63:0] t;
			res = rotl(words[1] * 64'd5, 7) * 64'd9;
			t = words[1] << 17;
			words[2] ^= words[0];
			words[3] ^= words[1];
			words[1] ^= words[2];
			words[0] ^= words[3];
			words[2] ^= t;
			words[3] = rotl(words[3], 45);
			return res;
		endfunction

		function logic [63:0] next_bounded(logic [63:0] bound);
			logic [63:0] floor_val;
			logic [63:0] v;
			if (bound == 64'd0) return 64'd0;
			floor_val = (64'd0 - bound) % bound;
			do v = next_raw(); while (v < floor_val);
			return v % bound;
		endfunction

		function void note_request(xo_pkg::xo_req_t r);
			logic [63:0] v;
			v = 64'd0;
			case (r.opcode)
				xo_pkg::OP_RESEED: load_seed(r.seed_value);
				xo_pkg::OP_RAW: v = next_raw();
				xo_pkg::OP_BOUNDED: v = next_bounded(r.draw_bound);
				default: v = 64'd0;
			endcase
			pending_values.push_back(v);
		endfunction

		function void check_value(logic [63:0] got);
			logic [63:0] want;
			if (pending_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending_values.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("random_value mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycle_count = 0;
	bit hold_off = 1'b0;
	rng_scoreboard board;
	xo_pkg::xo_req_t request_list [$];

	xo_req_if req ();
	xo_rsp_if rsp ();

	xoshiro256ss_generator dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
	end

	// Check every result transfer and record every command transfer.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && req.valid && req.ready) board.note_request(req.payload);
		if (arst_n && rsp.valid && rsp.ready) board.check_value(rsp.payload.random_value);
	end

	// Receiver stall pattern, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_off) rsp.ready <= 1'b0;
		else if (cycle_count % 2000 < 700) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function logic [63:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return 64'hffff_ffff_ffff_ffff;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return 64'($urandom_range(1, 1000));
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function xo_pkg::xo_req_t make_request(logic [1:0] op, logic [63:0] seed,
		logic [63:0] bound);
		xo_pkg::xo_req_t r;
		r.opcode = op;
		r.seed_value = seed;
		r.draw_bound = bound;
		return r;
	endfunction

	// Offer queued commands in bursts with random gaps.
	task automatic send_all();
		int burst;
		int gap;
		while (request_list.size() > 0) begin
			burst = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			while (burst > 0 && request_list.size() > 0) begin
				req.valid <= 1'b1;
				req.payload <= request_list.pop_front();
				do @(posedge clk); while (!req.ready);
				burst--;
			end
			if (gap > 0 && request_list.size() > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.pending_values.size() > 0) @(posedge clk);
	endtask

	initial begin
		logic [1:0] op;
		board = new();
		board.load_seed(64'd0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every opcode, field extremes, zero bound, bound of one.
		request_list.push_back(make_request(xo_pkg::OP_RAW, 64'd0, 64'd0));
		request_list.push_back(make_request(xo_pkg::OP_BOUNDED, 64'd0, 64'd0));
		request_list.push_back(make_request(xo_pkg::OP_BOUNDED, 64'd0, 64'd1));
		request_list.push_back(make_request(xo_pkg::OP_BOUNDED, 64'd0,
			64'hffff_ffff_ffff_ffff));
		request_list.push_back(make_request(xo_pkg::OP_BOUNDED, 64'd0,
			64'h8000_0000_0000_0001));
		request_list.push_back(make_request(xo_pkg::OP_BOUNDED, 64'd0, 64'd3));
		request_list.push_back(make_request(xo_pkg::OP_UNUSED, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff));
		request_list.push_back(make_request(xo_pkg::OP_RESEED, 64'hffff_ffff_ffff_ffff,
			64'd0));
		request_list.push_back(make_request(xo_pkg::OP_RAW, 64'd0, 64'd0));
		request_list.push_back(make_request(xo_pkg::OP_RESEED, 64'd0, 64'd0));
		request_list.push_back(make_request(xo_pkg::OP_RAW, 64'd0, 64'd0));
		request_list.push_back(make_request(xo_pkg::OP_RESEED, 64'h0123_4567_89ab_cdef,
			64'd0));
		request_list.push_back(make_request(xo_pkg::OP_RAW, 64'd0, 64'd0));
		send_all();

		// Pause the sender until every result is back.
		wait_drained();

		// Long receiver hold-off while commands keep coming.
		hold_off <= 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		for (int i = 0; i < 20; i++)
			request_list.push_back(make_request(xo_pkg::OP_RAW, pick_value(), pick_value()));
		send_all();

		// Random mix, mostly draws, occasional reseed and unused opcode.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 19))
				0, 1: op = xo_pkg::OP_RESEED;
				2: op = xo_pkg::OP_UNUSED;
				3, 4, 5, 6, 7, 8, 9, 10: op = xo_pkg::OP_RAW;
				default: op = xo_pkg::OP_BOUNDED;
			endcase
			request_list.push_back(make_request(op, pick_value(), pick_value()));
		end
		send_all();

		wait_drained();
		repeat (300) @(posedge clk);
		if (board.mismatches == 0 && board.pending_values.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
